// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Word width, operation codes and the types that the core, the shared adder
// and the top level have in common.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Internal arithmetic width. All sums and products wrap at this width.
    localparam int DATA_WIDTH = 32;
    // Width of the external operand and result fields.
    localparam int FIELD_W    = 32;
    // Counter width for bit positions 0 to DATA_WIDTH-1.
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [FIELD_W-1:0]    t_field;

    typedef enum logic [2:0] {
        FUNC_ADD      = 3'd0,
        FUNC_ADD_INT  = 3'd1,
        FUNC_MUL      = 3'd2,
        FUNC_MUL_INT  = 3'd3,
        FUNC_SIMPLIFY = 3'd4
    } t_func;

    // Request to and response from the shared adder/subtractor.
    typedef struct packed {
        t_word a;
        t_word b;
        logic  sub;
    } t_alu_req;

    typedef struct packed {
        t_word res;
        logic  cout;
    } t_alu_rsp;

    // Status of the sequencer as seen by the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    // Sign-extend a field to 64 bits, then keep the low DATA_WIDTH bits.
    function automatic t_word from_field(input t_field v);
        logic signed [FIELD_W-1:0] s;
        logic signed [63:0]        e;
        s = v;
        e = 64'(s);
        return e[DATA_WIDTH-1:0];
    endfunction

    // Sign-extend a word to 64 bits, then keep the low FIELD_W bits.
    function automatic t_field to_field(input t_word v);
        logic signed [DATA_WIDTH-1:0] s;
        logic signed [63:0]           e;
        s = v;
        e = 64'(s);
        return e[FIELD_W-1:0];
    endfunction

endpackage

// ===== src/rau_alu.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit shared adder
// One DATA_WIDTH adder/subtractor. With sub set, cout is high when a >= b.
// ----------------------------------------------------------------------------
module rau_alu (
    input  rau_pkg::t_alu_req i_req,
    output rau_pkg::t_alu_rsp o_rsp
);
    import rau_pkg::*;

    logic [DATA_WIDTH:0] sum;
    t_word               b_op;

    assign b_op = i_req.sub ? ~i_req.b : i_req.b;
    assign sum  = {1'b0, i_req.a} + {1'b0, b_op} + {{DATA_WIDTH{1'b0}}, i_req.sub};

    assign o_rsp.res  = sum[DATA_WIDTH-1:0];
    assign o_rsp.cout = sum[DATA_WIDTH];

endmodule

// ===== src/rau_core.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit sequencer
// Runs shift-add multiplication, binary gcd and restoring division, all on
// one shared adder, and holds the result until the top level takes it.
// ----------------------------------------------------------------------------
module rau_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_take,
    input  rau_pkg::t_func      i_func,
    input  rau_pkg::t_word      i_an,
    input  rau_pkg::t_word      i_ad,
    input  rau_pkg::t_word      i_bn,
    input  rau_pkg::t_word      i_bd,
    input  rau_pkg::t_word      i_iv,
    output rau_pkg::t_core_stat o_stat,
    output rau_pkg::t_word      o_rn,
    output rau_pkg::t_word      o_rd
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL, S_ABS_N, S_ABS_D, S_TZ, S_XODD,
        S_GCD, S_DIV_LOAD, S_DIV, S_NEG, S_DONE
    } t_state;

    typedef enum logic [2:0] {SEL_AN, SEL_AD, SEL_BN, SEL_BD, SEL_IV, SEL_ONE} t_sel;
    typedef enum logic [1:0] {ACC_ZERO, ACC_AN, ACC_KEEP} t_acc;
    typedef enum logic [1:0] {DST_NONE, DST_RN, DST_RD} t_dst;

    typedef struct packed {
        t_sel m_sel;
        t_sel q_sel;
        t_acc acc_init;
        t_dst dst;
        logic last;
    } t_pass;

    t_state           r_state;
    t_func            r_func;
    logic [1:0]       r_phase;
    t_word            r_an, r_ad, r_bn, r_bd, r_iv;
    t_word            r_acc, r_m, r_q;
    t_word            r_rn, r_rd;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_cnt;

    t_pass    pass;
    t_word    m_val, q_val;
    t_word    rem_sh;
    t_word    q_signed;
    logic     neg_sel;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    rau_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Multiply passes. Each pass adds m*q into the accumulator; the add with
    // unequal denominators accumulates both cross products before storing.
    always_comb begin
        pass = '{SEL_AN, SEL_ONE, ACC_ZERO, DST_RN, 1'b1};
        case (r_func)
            FUNC_ADD: begin
                if (r_ad == r_bd) begin
                    pass = '{SEL_BN, SEL_ONE, ACC_AN, DST_RN, 1'b1};
                end else begin
                    case (r_phase)
                        2'd0:    pass = '{SEL_AN, SEL_BD, ACC_ZERO, DST_NONE, 1'b0};
                        2'd1:    pass = '{SEL_BN, SEL_AD, ACC_KEEP, DST_RN, 1'b0};
                        default: pass = '{SEL_AD, SEL_BD, ACC_ZERO, DST_RD, 1'b1};
                    endcase
                end
            end
            FUNC_ADD_INT: pass = '{SEL_IV, SEL_AD, ACC_AN, DST_RN, 1'b1};
            FUNC_MUL: begin
                if (r_phase == 2'd0) begin
                    pass = '{SEL_AN, SEL_BN, ACC_ZERO, DST_RN, 1'b0};
                end else begin
                    pass = '{SEL_AD, SEL_BD, ACC_ZERO, DST_RD, 1'b1};
                end
            end
            FUNC_MUL_INT: pass = '{SEL_AN, SEL_IV, ACC_ZERO, DST_RN, 1'b1};
            default: ;
        endcase
    end

    always_comb begin
        case (pass.m_sel)
            SEL_AN:  m_val = r_an;
            SEL_AD:  m_val = r_ad;
            SEL_BN:  m_val = r_bn;
            SEL_BD:  m_val = r_bd;
            SEL_IV:  m_val = r_iv;
            default: m_val = DATA_WIDTH'(1);
        endcase
        case (pass.q_sel)
            SEL_AN:  q_val = r_an;
            SEL_AD:  q_val = r_ad;
            SEL_BN:  q_val = r_bn;
            SEL_BD:  q_val = r_bd;
            SEL_IV:  q_val = r_iv;
            default: q_val = DATA_WIDTH'(1);
        endcase
    end

    assign rem_sh   = {r_acc[DATA_WIDTH-2:0], r_q[DATA_WIDTH-1]};
    assign neg_sel  = (r_phase == 2'd0) ? r_an[DATA_WIDTH-1] : r_ad[DATA_WIDTH-1];
    assign q_signed = neg_sel ? alu_rsp.res : r_q;

    // Operand steering for the shared adder.
    always_comb begin
        alu_req.a   = r_acc;
        alu_req.b   = r_m;
        alu_req.sub = 1'b0;
        case (r_state)
            S_ABS_N: begin
                alu_req.a   = '0;
                alu_req.b   = r_an;
                alu_req.sub = 1'b1;
            end
            S_ABS_D: begin
                alu_req.a   = '0;
                alu_req.b   = r_ad;
                alu_req.sub = 1'b1;
            end
            S_GCD: begin
                alu_req.a   = r_q;
                alu_req.b   = r_m;
                alu_req.sub = 1'b1;
            end
            S_DIV: begin
                alu_req.a   = rem_sh;
                alu_req.b   = r_m;
                alu_req.sub = 1'b1;
            end
            S_NEG: begin
                alu_req.a   = '0;
                alu_req.b   = r_q;
                alu_req.sub = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_func  <= i_func;
                        r_an    <= i_an;
                        r_ad    <= i_ad;
                        r_bn    <= i_bn;
                        r_bd    <= i_bd;
                        r_iv    <= i_iv;
                        r_rn    <= i_an;
                        r_rd    <= i_ad;
                        r_phase <= '0;
                        r_k     <= '0;
                        if (i_func inside {FUNC_ADD, FUNC_ADD_INT, FUNC_MUL, FUNC_MUL_INT}) begin
                            r_state <= S_LOAD;
                        end else if (i_func == FUNC_SIMPLIFY && i_an != '0 && i_ad != '0) begin
                            r_state <= S_ABS_N;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_LOAD: begin
                    r_m <= m_val;
                    r_q <= q_val;
                    case (pass.acc_init)
                        ACC_ZERO: r_acc <= '0;
                        ACC_AN:   r_acc <= r_an;
                        default:  ;
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_q != '0) begin
                        if (r_q[0]) begin
                            r_acc <= alu_rsp.res;
                        end
                        r_m <= {r_m[DATA_WIDTH-2:0], 1'b0};
                        r_q <= {1'b0, r_q[DATA_WIDTH-1:1]};
                    end else begin
                        case (pass.dst)
                            DST_RN:  r_rn <= r_acc;
                            DST_RD:  r_rd <= r_acc;
                            default: ;
                        endcase
                        if (pass.last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_phase <= r_phase + 2'd1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                // The magnitudes are kept in the B registers, which simplify
                // does not otherwise use, as the later dividends.
                S_ABS_N: begin
                    r_m     <= r_an[DATA_WIDTH-1] ? alu_rsp.res : r_an;
                    r_bn    <= r_an[DATA_WIDTH-1] ? alu_rsp.res : r_an;
                    r_state <= S_ABS_D;
                end
                S_ABS_D: begin
                    r_q     <= r_ad[DATA_WIDTH-1] ? alu_rsp.res : r_ad;
                    r_bd    <= r_ad[DATA_WIDTH-1] ? alu_rsp.res : r_ad;
                    r_state <= S_TZ;
                end
                S_TZ: begin
                    if (!r_m[0] && !r_q[0]) begin
                        r_m <= {1'b0, r_m[DATA_WIDTH-1:1]};
                        r_q <= {1'b0, r_q[DATA_WIDTH-1:1]};
                        r_k <= r_k + CNT_W'(1);
                    end else begin
                        r_state <= S_XODD;
                    end
                end
                S_XODD: begin
                    if (!r_m[0]) begin
                        r_m <= {1'b0, r_m[DATA_WIDTH-1:1]};
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (!r_q[0]) begin
                        r_q <= {1'b0, r_q[DATA_WIDTH-1:1]};
                    end else if (alu_rsp.cout) begin
                        r_q <= alu_rsp.res;
                        if (alu_rsp.res == '0) begin
                            r_m     <= r_m << r_k;
                            r_state <= S_DIV_LOAD;
                        end
                    end else begin
                        r_m <= r_q;
                        r_q <= r_m;
                    end
                end
                S_DIV_LOAD: begin
                    r_acc   <= '0;
                    r_q     <= (r_phase == 2'd0) ? r_bn : r_bd;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_q   <= {r_q[DATA_WIDTH-2:0], alu_rsp.cout};
                    r_acc <= alu_rsp.cout ? alu_rsp.res : rem_sh;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                        r_state <= S_NEG;
                    end
                end
                S_NEG: begin
                    if (r_phase == 2'd0) begin
                        r_rn    <= q_signed;
                        r_phase <= 2'd1;
                        r_state <= S_DIV_LOAD;
                    end else begin
                        r_rd    <= q_signed;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_rn        = r_rn;
    assign o_rd        = r_rd;

    // The partial remainder always stays below the divisor.
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_acc < r_m)
        else $error("division remainder not below divisor");

    // The gcd loop keeps the operand in r_m odd and nonzero.
    a_gcd_x_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GCD |-> r_m[0] && r_m != '0)
        else $error("gcd operand lost its odd form");

    // Shared factors of two are only stripped from nonzero magnitudes.
    a_tz_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TZ |-> r_m != '0 && r_q != '0)
        else $error("zero magnitude reached the gcd");

    // A finished result holds until the top level takes it.
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !i_take |=> r_state == S_DONE && $stable(r_rn) && $stable(r_rd))
        else $error("result changed before it was taken");

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds or multiplies rationals, or reduces one by the gcd of its parts, using
// a multi-cycle sequencer around a single shared adder.
// ----------------------------------------------------------------------------
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+-----------------------------------
//   input    | i_in_valid   | o_in_ready   | i_func, i_a_num, i_a_den,
//            |              |              | i_b_num, i_b_den, i_int_operand
//   output   | o_out_valid  | i_out_ready  | o_res_num, o_res_den,
//            |              |              | o_zero_den_error
//
// One transaction is worked on at a time; o_in_ready is high only while the
// sequencer is idle. Every multiply pass is a shift-add loop on the shared
// adder (W = DATA_WIDTH). An add with unequal denominators runs three passes,
// a multiply two, and the other arithmetic operations one. Simplify takes
// the magnitudes, strips the shared factors of two, runs the binary gcd loop
// and then two W-bit restoring divisions.
// Unused codes and simplify with a zero part go straight to the done state.
// Reset is synchronous; there is no memory to clear.
// The output register holds one finished result; while it waits, the next
// transaction may be accepted and computed, and it then stays in the
// sequencer until the output register frees up.
//
module rational_arithmetic_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_func,
    input  rau_pkg::t_field       i_a_num,
    input  rau_pkg::t_field       i_a_den,
    input  rau_pkg::t_field       i_b_num,
    input  rau_pkg::t_field       i_b_den,
    input  rau_pkg::t_field       i_int_operand,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rau_pkg::t_field       o_res_num,
    output rau_pkg::t_field       o_res_den,
    output logic                  o_zero_den_error
);
    import rau_pkg::*;

    t_core_stat core_stat;
    t_word      core_rn;
    t_word      core_rd;
    logic       core_start;
    logic       core_take;

    logic       r_out_valid;
    t_field     r_out_num;
    t_field     r_out_den;
    logic       r_out_err;

    // A transaction starts the sequencer only when it is idle.
    assign o_in_ready = core_stat.idle;
    assign core_start = i_in_valid && core_stat.idle;

    // A finished result moves into the output register when that register is
    // empty or is being emptied in the same cycle.
    assign core_take = core_stat.done && (!r_out_valid || i_out_ready);

    rau_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_take  (core_take),
        .i_func  (t_func'(i_func)),
        .i_an    (from_field(i_a_num)),
        .i_ad    (from_field(i_a_den)),
        .i_bn    (from_field(i_b_num)),
        .i_bd    (from_field(i_b_den)),
        .i_iv    (from_field(i_int_operand)),
        .o_stat  (core_stat),
        .o_rn    (core_rn),
        .o_rd    (core_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The error flag looks at the denominator at the internal width, before
    // it is fitted to the output field.
    always_ff @(posedge i_clk) begin
        if (core_take) begin
            r_out_num <= to_field(core_rn);
            r_out_den <= to_field(core_rd);
            r_out_err <= (core_rd == '0);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_res_num        = r_out_num;
    assign o_res_den        = r_out_den;
    assign o_zero_den_error = r_out_err;

endmodule
